[rtl/core/save_image_validator_macros.svh]
// Assertion macros shared by the save image validator RTL.
`ifndef SAVE_IMAGE_VALIDATOR_MACROS_SVH
`define SAVE_IMAGE_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("save image validator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SIV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("save image validator: next-cycle check failed");

`endif

[rtl/core/siv_pkg.sv]
package siv_pkg;

  localparam int CountW = 18;

  localparam logic [CountW-1:0] CountMax  = 18'h3ffff;
  localparam logic [CountW-1:0] TailLen   = 18'd48;
  localparam logic [CountW-1:0] BlankLen  = 18'd32768;
  localparam logic [CountW-1:0] SmallRam  = 18'd512;
  localparam logic [5:0]        BankLen   = 6'd20;
  localparam logic [5:0]        StampOff  = 6'd40;
  localparam logic [63:0]       StampFloor = 64'd852076800;

  localparam logic [7:0] CartSmallA  = 8'h05;
  localparam logic [7:0] CartSmallB  = 8'h06;
  localparam logic [7:0] CartClockA  = 8'h0f;
  localparam logic [7:0] CartClockB  = 8'h10;
  localparam logic [7:0] RamCodeLimit = 8'd6;

  localparam logic [7:0] SecMinLimit = 8'd60;
  localparam logic [7:0] HourLimit   = 8'd24;
  localparam logic [7:0] DayHiMask   = 8'h3e;

  typedef enum logic [1:0] {
    CFG_CART_TYPE    = 2'd0,
    CFG_RAM_SIZE     = 2'd1,
    CFG_CURRENT_TIME = 2'd2
  } cfg_idx_t;

  // Expected battery RAM length for a size code and cartridge type.
  function automatic logic [CountW-1:0] ram_length(input logic [7:0] code,
                                                   input logic [7:0] ctype);
    logic [CountW-1:0] len;
    case (code)
      8'd0:    len = 18'd0;
      8'd1:    len = 18'd2048;
      8'd2:    len = 18'd8192;
      8'd3:    len = 18'd32768;
      8'd4:    len = 18'd131072;
      8'd5:    len = 18'd65536;
      default: len = 18'd0;
    endcase
    if (len == '0 && (ctype == CartSmallA || ctype == CartSmallB)) begin
      len = SmallRam;
    end
    return len;
  endfunction

endpackage

[rtl/core/save_image_validator.sv]
// Checks a cartridge save image streamed one byte per beat and gives one verdict beat
// for each image after the byte marked last. A byte is taken every clock cycle unless
// the verdict stage is full and stalled; it is loaded at the edge that takes the last
// byte and out_valid follows from the output register, so that a stalled output does
// not hold up the input until both are full. Configuration may be written while no
// verdict is outstanding; each byte is classified with the registers in force when it
// is taken, and the verdict uses those in force when it is formed.
`include "save_image_validator_macros.svh"

module save_image_validator
  import siv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_save_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_image_valid
);

  logic [7:0]        cart_type_r;
  logic [7:0]        ram_size_code_r;
  logic [62:0]       current_time_r;

  logic [CountW-1:0] byte_count_r, byte_count_nxt;
  logic              nonzero_seen_r, nonzero_seen_nxt;
  logic              clock_fault_r, clock_fault_nxt;
  logic [63:0]       saved_stamp_r, saved_stamp_nxt;

  logic              v_valid_r;
  logic [CountW-1:0] v_len_r;
  logic              v_nonzero_r;
  logic              v_fault_r;
  logic [63:0]       v_stamp_r;

  logic              out_valid_r;
  logic              out_image_valid_r;

  logic              in_acc;
  logic              v_adv;
  logic [CountW-1:0] ram_now;
  logic [CountW-1:0] off_full;
  logic              in_tail;
  logic [5:0]        off;
  logic              in_bank;
  logic [4:0]        bank_pos;
  logic [2:0]        stamp_lane;
  logic              bank_bad;
  logic              is_clock;
  logic              verdict;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_type_r     <= '0;
      ram_size_code_r <= '0;
      current_time_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CART_TYPE:    cart_type_r     <= cfg_wdata[7:0];
        CFG_RAM_SIZE:     ram_size_code_r <= cfg_wdata[7:0];
        CFG_CURRENT_TIME: current_time_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_acc   = in_valid && in_ready;
  assign v_adv    = v_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !v_valid_r || v_adv;

  // Position of the incoming byte relative to the clock tail.
  assign ram_now    = ram_length(ram_size_code_r, cart_type_r);
  assign off_full   = byte_count_r - ram_now;
  assign in_tail    = (byte_count_r != CountMax) && (byte_count_r >= ram_now) &&
                      (off_full < TailLen);
  assign off        = off_full[5:0];
  assign in_bank    = off < StampOff;
  assign bank_pos   = (off < BankLen) ? off[4:0] : 5'(off - BankLen);
  assign stamp_lane = 3'(off - StampOff);

  always_comb begin
    bank_bad = 1'b0;
    if ((bank_pos == 5'd0 || bank_pos == 5'd4) && in_save_byte >= SecMinLimit) begin
      bank_bad = 1'b1;
    end
    if (bank_pos == 5'd8 && in_save_byte >= HourLimit) begin
      bank_bad = 1'b1;
    end
    if (bank_pos == 5'd16 && (in_save_byte & DayHiMask) != 8'd0) begin
      bank_bad = 1'b1;
    end
    if (bank_pos[1:0] != 2'd0 && in_save_byte != 8'd0) begin
      bank_bad = 1'b1;
    end
  end

  always_comb begin
    byte_count_nxt   = (byte_count_r != CountMax) ? byte_count_r + 18'd1 : byte_count_r;
    nonzero_seen_nxt = nonzero_seen_r || (in_save_byte != 8'd0);
    clock_fault_nxt  = clock_fault_r || (in_tail && in_bank && bank_bad);
    saved_stamp_nxt  = saved_stamp_r;
    if (in_tail && !in_bank) begin
      saved_stamp_nxt[{stamp_lane, 3'b000} +: 8] =
        saved_stamp_r[{stamp_lane, 3'b000} +: 8] | in_save_byte;
    end
  end

  // Per-image state, cleared again once the last byte hands it on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      nonzero_seen_r <= 1'b0;
      clock_fault_r  <= 1'b0;
      saved_stamp_r  <= '0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        byte_count_r   <= '0;
        nonzero_seen_r <= 1'b0;
        clock_fault_r  <= 1'b0;
        saved_stamp_r  <= '0;
      end else begin
        byte_count_r   <= byte_count_nxt;
        nonzero_seen_r <= nonzero_seen_nxt;
        clock_fault_r  <= clock_fault_nxt;
        saved_stamp_r  <= saved_stamp_nxt;
      end
    end
  end

  // Verdict stage: a snapshot of the finished image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else if (in_acc && in_last_byte) begin
      v_valid_r <= 1'b1;
    end else if (v_adv) begin
      v_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      v_len_r     <= byte_count_nxt;
      v_nonzero_r <= nonzero_seen_nxt;
      v_fault_r   <= clock_fault_nxt;
      v_stamp_r   <= saved_stamp_nxt;
    end
  end

  assign is_clock = (cart_type_r == CartClockA) || (cart_type_r == CartClockB);

  always_comb begin
    if (ram_size_code_r >= RamCodeLimit) begin
      verdict = 1'b0;
    end else if (v_len_r == BlankLen && !v_nonzero_r) begin
      verdict = 1'b0;
    end else if (!is_clock) begin
      verdict = v_len_r == ram_now;
    end else begin
      verdict = (v_len_r == ram_now + TailLen) && !v_fault_r &&
                (v_stamp_r >= StampFloor) && (v_stamp_r <= {1'b0, current_time_r});
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_adv) begin
      out_image_valid_r <= verdict;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_image_valid = out_image_valid_r;

  `SIV_ASSERT_NEXT(a_last_loads_verdict, in_acc && in_last_byte, v_valid_r)
  `SIV_ASSERT_NEXT(a_last_clears_state, in_acc && in_last_byte,
                   byte_count_r == '0 && !nonzero_seen_r && !clock_fault_r)
  `SIV_ASSERT_NEXT(a_count_steps, in_acc && !in_last_byte && byte_count_r != CountMax,
                   byte_count_r == $past(byte_count_r) + 18'd1)
  `SIV_ASSERT_IMPL(a_ready_when_free, !v_valid_r, in_ready)

endmodule
